// ===== rtl/lpsbe_pkg.sv =====
// Shared types and constants for the LED pixel store and blend engine.
// Depends on nothing; the blend unit, the engine and the bench files import it.
`default_nettype none

package lpsbe_pkg;

  // Default size of the pixel store.
  localparam int NUM_PIXELS_DEF = 256;

  // Reset value of the active length register.
  localparam logic [8:0] ACTIVE_LEDS_RST = 9'd256;

  // Largest value of one colour channel.
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // Draw modes held in the draw mode register; the unused code acts as replace.
  localparam logic [1:0] DRAW_REPLACE = 2'd0;
  localparam logic [1:0] DRAW_ADD     = 2'd1;
  localparam logic [1:0] DRAW_SUB     = 2'd2;

  // One RGBW pixel: red 7:0, green 15:8, blue 23:16, white 31:24.
  typedef logic [31:0] pixel_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_DRAW_MODE   = 1'b0,
    REG_ACTIVE_LEDS = 1'b1
  } cfg_reg_t;

  // Operation of the shared per-channel pixel unit.
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_STEP = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] step_amt;
  } alu_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_APPLY,
    ST_FILL,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lpsbe_cmd_if.sv =====
// Command channel of the LED pixel store: valid/ready plus one command item.
// Stands alone; the widths are fixed by the command format.
`default_nettype none

interface lpsbe_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] pixel_index;
  logic [8:0] range_count;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_white;
  logic [7:0] step_size;

  modport source (
    output valid, command, pixel_index, range_count,
           in_red, in_green, in_blue, in_white, step_size,
    input  ready
  );

  modport sink (
    input  valid, command, pixel_index, range_count,
           in_red, in_green, in_blue, in_white, step_size,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lpsbe_res_if.sv =====
// Result channel of the LED pixel store: valid/ready plus one result item.
// Stands alone; the widths are fixed by the result format.
`default_nettype none

interface lpsbe_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_white;
  logic       status;

  modport source (
    output valid, out_red, out_green, out_blue, out_white, status,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_white, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lpsbe_cfg_if.sv =====
// Configuration write channel of the LED pixel store: valid/ready, index, data.
// Stands alone; data is as wide as the widest register.
`default_nettype none

interface lpsbe_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [8:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lpsbe_blend.sv =====
// Per-channel pixel unit: replace, saturating add, saturating subtract, step.
// Depends on lpsbe_pkg for the pixel type and operation codes.
`default_nettype none

module lpsbe_blend
  import lpsbe_pkg::*;
(
  input  alu_ctrl_t ctrl,
  input  pixel_t    old_px,
  input  pixel_t    color,
  output pixel_t    new_px
);

  always_comb begin
    logic [7:0] o;
    logic [7:0] t;
    logic [7:0] s;
    logic [8:0] sum;
    logic [7:0] diff;
    logic [7:0] r;
    new_px = '0;
    for (int c = 0; c < 4; c++) begin
      o    = old_px[8*c +: 8];
      t    = color[8*c +: 8];
      s    = ctrl.step_amt;
      sum  = {1'b0, o} + {1'b0, t};
      diff = (t >= o) ? (t - o) : (o - t);
      case (ctrl.op)
        OP_ADD:  r = sum[8] ? CHAN_MAX : sum[7:0];
        OP_SUB:  r = (t >= o) ? 8'd0 : (o - t);
        // Move by at most the step, landing on the target when it is close.
        OP_STEP: begin
          if (diff <= s) begin
            r = t;
          end else if (t >= o) begin
            r = o + s;
          end else begin
            r = o - s;
          end
        end
        default: r = t;
      endcase
      new_px[8*c +: 8] = r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/led_pixel_store_blend_engine.sv =====
// RGBW pixel store with draw-mode blending. After reset the store is cleared one pixel a
// cycle (commands held off); configuration writes are taken throughout. A write or read
// runs through fetch, apply and finish, one past the active length or an empty range
// goes straight to finish, and a fill or step walks the pixels covered after clamping.
// One item is in work at a time; the single-port store and its registered read set the
// fetch-then-apply read-modify-write of each stepped pixel. Reset is synchronous, active high.
`default_nettype none

module led_pixel_store_blend_engine
  import lpsbe_pkg::*;
#(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lpsbe_cmd_if.sink    cmd,
  lpsbe_res_if.source  res,
  lpsbe_cfg_if.sink    cfg
);

  // Address width of the store, and a counter width that holds both the
  // store size and the end of any range (start plus count reaches 766).
  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam logic [CW-1:0] NUM_PIX_C = CW'(NUM_PIXELS);
  localparam logic [CW-1:0] LAST_PIX  = CW'(NUM_PIXELS - 1);

  // Control state.
  state_t      state, state_next;
  logic [CW-1:0] cur, cur_next;
  logic        res_valid;
  logic [1:0]  draw_mode;
  logic [8:0]  active_leds;

  // Payload of the item in work.
  cmd_t        op_cmd;
  pixel_t      color;
  logic [7:0]  step_amt;
  logic [CW-1:0] stop;
  pixel_t      hold_word, hold_word_next;
  logic        hold_status, hold_status_next;
  pixel_t      res_word;
  logic        res_status;

  // Pixel store, single port: at most one write and one registered read per cycle, at one address.
  pixel_t      mem [NUM_PIXELS];
  pixel_t      rd_word;
  logic        mem_we;
  pixel_t      mem_wdata;
  logic [AW-1:0] mem_addr;

  logic          take;
  logic          load_res;
  logic [CW-1:0] len;
  logic [CW-1:0] first;
  logic [CW-1:0] span_end;
  logic [CW-1:0] stop_calc;
  logic [CW-1:0] cur_inc;
  alu_ctrl_t     alu_ctrl;
  pixel_t        blend_out;

  // The active length is the configured length, clamped to the store size.
  assign len       = (CW'(active_leds) > NUM_PIX_C) ? NUM_PIX_C : CW'(active_leds);
  assign first     = CW'(cmd.pixel_index);
  assign span_end  = first + CW'(cmd.range_count);
  assign stop_calc = (span_end > len) ? len : span_end;
  assign cur_inc   = cur + CW'(1);
  assign mem_addr  = cur[AW-1:0];

  assign cmd.ready = (state == ST_IDLE);
  assign take      = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // A step command always steps; a pixel write follows the draw mode, and the
  // unused mode code behaves as replace.
  always_comb begin
    alu_ctrl.step_amt = step_amt;
    if (op_cmd == CMD_STEP) begin
      alu_ctrl.op = OP_STEP;
    end else begin
      case (draw_mode)
        DRAW_ADD: alu_ctrl.op = OP_ADD;
        DRAW_SUB: alu_ctrl.op = OP_SUB;
        default:  alu_ctrl.op = OP_SET;
      endcase
    end
  end

  lpsbe_blend u_blend (
    .ctrl   (alu_ctrl),
    .old_px (rd_word),
    .color  (color),
    .new_px (blend_out)
  );

  // Sequencer. A range is walked one pixel at a time: a fill writes each
  // cycle, a step reads in one cycle and writes the stepped pixel in the next.
  always_comb begin
    state_next       = state;
    cur_next         = cur;
    mem_we           = 1'b0;
    mem_wdata        = blend_out;
    load_res         = 1'b0;
    hold_word_next   = hold_word;
    hold_status_next = hold_status;

    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        cur_next  = cur_inc;
        if (cur == LAST_PIX) begin
          cur_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (take) begin
          hold_word_next   = '0;
          hold_status_next = 1'b0;
          cur_next         = first;
          if (cmd_t'(cmd.command) == CMD_WRITE || cmd_t'(cmd.command) == CMD_READ) begin
            // A single pixel beyond the active length is flagged and left alone.
            if (first >= len) begin
              hold_status_next = 1'b1;
              state_next       = ST_FINISH;
            end else begin
              state_next = ST_FETCH;
            end
          end else if (first >= stop_calc) begin
            state_next = ST_FINISH;
          end else if (cmd_t'(cmd.command) == CMD_FILL) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end

      ST_FETCH: begin
        state_next = ST_APPLY;
      end

      ST_APPLY: begin
        case (op_cmd)
          CMD_READ: begin
            hold_word_next = rd_word;
            state_next     = ST_FINISH;
          end
          CMD_WRITE: begin
            mem_we     = 1'b1;
            state_next = ST_FINISH;
          end
          CMD_STEP: begin
            mem_we     = 1'b1;
            cur_next   = cur_inc;
            state_next = (cur_inc >= stop) ? ST_FINISH : ST_FETCH;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end

      ST_FILL: begin
        mem_we     = 1'b1;
        mem_wdata  = color;
        cur_next   = cur_inc;
        if (cur_inc >= stop) begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // The result register is free, or its item is being taken this cycle.
        if (!res_valid || res.ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cur         <= '0;
      res_valid   <= 1'b0;
      draw_mode   <= DRAW_REPLACE;
      active_leds <= ACTIVE_LEDS_RST;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_DRAW_MODE:   draw_mode   <= cfg.data[1:0];
          REG_ACTIVE_LEDS: active_leds <= cfg.data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_cmd   <= cmd_t'(cmd.command);
      color    <= {cmd.in_white, cmd.in_blue, cmd.in_green, cmd.in_red};
      step_amt <= cmd.step_size;
      stop     <= stop_calc;
    end
    hold_word   <= hold_word_next;
    hold_status <= hold_status_next;
    if (load_res) begin
      res_word   <= hold_word;
      res_status <= hold_status;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_word <= mem[mem_addr];
  end

  assign res.valid     = res_valid;
  assign res.out_red   = res_word[7:0];
  assign res.out_green = res_word[15:8];
  assign res.out_blue  = res_word[23:16];
  assign res.out_white = res_word[31:24];
  assign res.status    = res_status;

endmodule

`default_nettype wire

// ===== bench/lpsbe_pixel_checker.sv =====
`timescale 1ns / 1ps
// Checker for the LED pixel store: keeps its own copy of the RGBW store and registers,
// predicts one result per accepted command item and compares the returned items.
// Depends on lpsbe_pkg and the command, result and configuration interfaces.

module lpsbe_pixel_checker
  import lpsbe_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  lpsbe_cmd_if   cmd,
  lpsbe_res_if   res,
  lpsbe_cfg_if   cfg,
  output int     fail_count,
  output int     pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       status;
  } pixel_result_t;

  pixel_t        strip_copy [NUM_PIXELS_DEF];
  logic [1:0]    draw_mode_copy;
  logic [8:0]    active_leds_copy;
  pixel_result_t expected_pixels [$];
  pixel_result_t want;
  int            mismatches;

  function automatic pixel_t blend_pixel(pixel_t old, pixel_t col, logic [1:0] mode);
    pixel_t     word;
    logic [7:0] o;
    logic [7:0] v;
    logic [8:0] sum;
    for (int c = 0; c < 4; c++) begin
      o = old[8*c +: 8];
      v = col[8*c +: 8];
      sum = {1'b0, o} + {1'b0, v};
      case (mode)
        DRAW_ADD: begin
          word[8*c +: 8] = sum[8] ? CHAN_MAX : sum[7:0];
        end
        DRAW_SUB: begin
          word[8*c +: 8] = (v >= o) ? 8'd0 : o - v;
        end
        default: begin
          word[8*c +: 8] = v;
        end
      endcase
    end
    return word;
  endfunction

  // Each channel moves towards its target by at most the step, snapping when close.
  function automatic pixel_t step_pixel(pixel_t old, pixel_t col, logic [7:0] amt);
    pixel_t     word;
    logic [7:0] o;
    logic [7:0] t;
    for (int c = 0; c < 4; c++) begin
      o = old[8*c +: 8];
      t = col[8*c +: 8];
      if (t >= o) begin
        word[8*c +: 8] = (t - o <= amt) ? t : o + amt;
      end else begin
        word[8*c +: 8] = (o - t <= amt) ? t : o - amt;
      end
    end
    return word;
  endfunction

  function automatic pixel_result_t execute_command(cmd_t op, logic [7:0] idx,
                                                    logic [8:0] cnt, pixel_t col,
                                                    logic [7:0] amt);
    pixel_result_t r;
    int            strip_len;
    int            stop;
    pixel_t        word;
    r = '0;
    strip_len = (active_leds_copy > NUM_PIXELS_DEF) ? NUM_PIXELS_DEF : int'(active_leds_copy);
    if (op == CMD_WRITE || op == CMD_READ) begin
      if (int'(idx) >= strip_len) begin
        r.status = 1'b1;
      end else if (op == CMD_WRITE) begin
        strip_copy[idx] = blend_pixel(strip_copy[idx], col, draw_mode_copy);
      end else begin
        word = strip_copy[idx];
        r.red = word[7:0];
        r.green = word[15:8];
        r.blue = word[23:16];
        r.white = word[31:24];
      end
    end else begin
      stop = int'(idx) + int'(cnt);
      if (stop > strip_len) stop = strip_len;
      for (int p = int'(idx); p < stop; p++) begin
        if (op == CMD_FILL) strip_copy[p] = col;
        else strip_copy[p] = step_pixel(strip_copy[p], col, amt);
      end
    end
    return r;
  endfunction

  function automatic int field_mismatch(string field, logic [7:0] exp_val, logic [7:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (strip_copy[i]) strip_copy[i] = '0;
      draw_mode_copy = DRAW_REPLACE;
      active_leds_copy = ACTIVE_LEDS_RST;
      expected_pixels.delete();
      pending <= 0;
      fail_count <= 0;
    end else begin
      mismatches = 0;
      if (res.valid && res.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result item with no command outstanding: status %0d", res.status);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          mismatches += field_mismatch("out_red", want.red, res.out_red);
          mismatches += field_mismatch("out_green", want.green, res.out_green);
          mismatches += field_mismatch("out_blue", want.blue, res.out_blue);
          mismatches += field_mismatch("out_white", want.white, res.out_white);
          mismatches += field_mismatch("status", {7'd0, want.status}, {7'd0, res.status});
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_DRAW_MODE) draw_mode_copy = cfg.data[1:0];
        else active_leds_copy = cfg.data;
      end
      if (cmd.valid && cmd.ready) begin
        expected_pixels.push_back(execute_command(cmd_t'(cmd.command), cmd.pixel_index,
            cmd.range_count, {cmd.in_white, cmd.in_blue, cmd.in_green, cmd.in_red},
            cmd.step_size));
      end
      pending <= expected_pixels.size();
      fail_count <= fail_count + mismatches;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the LED pixel store testbench: clock, reset, command and configuration stimulus,
// result back-pressure and the verdict. Depends on lpsbe_pkg, the three channel
// interfaces, the block itself and lpsbe_pixel_checker.

module tb_top;
  import lpsbe_pkg::*;

  // The watchdog is far above the slowest run the stimulus below can produce, even if
  // every item were a step over the whole strip under the longest stalls.
  localparam int LIMIT_CYCLES = 5_000_000;
  // The one long hold-off of the result side, and the command count that starts it.
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_ITEM = 700;

  logic clk = 1'b0;
  logic rst;
  bit   steady;
  bit   hold_done;
  int   items_sent;
  int   fail_count;
  int   pending;

  lpsbe_cmd_if cmd_ch ();
  lpsbe_res_if res_ch ();
  lpsbe_cfg_if cfg_ch ();

  led_pixel_store_blend_engine dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  lpsbe_pixel_checker pixel_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle gaps: mostly none or a few cycles, now and then a long one. In a steady
  // phase both sides run flat out so that back-to-back traffic is seen as well.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Offers one command item and returns at the clock edge at which it is taken. Valid
  // is only lowered when a gap follows, so a back-to-back item keeps it high.
  task automatic send_command(cmd_t op, logic [7:0] idx, logic [8:0] cnt, pixel_t col,
                              logic [7:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.pixel_index <= idx;
    cmd_ch.range_count <= cnt;
    cmd_ch.in_red <= col[7:0];
    cmd_ch.in_green <= col[15:8];
    cmd_ch.in_blue <= col[23:16];
    cmd_ch.in_white <= col[31:24];
    cmd_ch.step_size <= amt;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Random commands. Pixel indices lean towards the first few pixels so that writes,
  // steps and reads keep meeting each other and saturation is reached. Range lengths
  // are mostly short, as a stepped range reads and writes each pixel in turn; a few are
  // long, up to a count of 511, and often run past the end of the strip.
  task automatic send_random_command();
    cmd_t       op;
    int         r;
    logic [7:0] idx;
    logic [8:0] cnt;
    pixel_t     col;
    logic [7:0] amt;
    r = int'($urandom_range(0, 99));
    if (r < 35) op = CMD_WRITE;
    else if (r < 65) op = CMD_READ;
    else if (r < 80) op = CMD_FILL;
    else op = CMD_STEP;
    idx = ($urandom_range(0, 99) < 40) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    r = int'($urandom_range(0, 99));
    if (r < 88) cnt = 9'($urandom_range(0, 12));
    else if (r < 97) cnt = 9'($urandom_range(13, 64));
    else cnt = 9'($urandom_range(65, 511));
    for (int c = 0; c < 4; c++) begin
      r = int'($urandom_range(0, 9));
      if (r == 0) col[8*c +: 8] = 8'h00;
      else if (r == 1) col[8*c +: 8] = CHAN_MAX;
      else col[8*c +: 8] = 8'($urandom_range(0, 255));
    end
    r = int'($urandom_range(0, 99));
    if (r < 15) amt = 8'd0;
    else if (r < 25) amt = 8'hFF;
    else if (r < 70) amt = 8'($urandom_range(1, 16));
    else amt = 8'($urandom_range(0, 255));
    send_command(op, idx, cnt, col, amt);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [8:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every command item has had its result, plus a short margin. The first
  // edge lets the checker count an item that was taken at the edge of the call.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic [8:0] mode_word, logic [8:0] leds, int count, bit quiet);
    settle();
    write_reg(REG_DRAW_MODE, mode_word);
    write_reg(REG_ACTIVE_LEDS, leds);
    steady = quiet;
    repeat (count) send_random_command();
  endtask

  // Result side: random stalls, plus one long hold-off part way through the run. The
  // sender carries on offering items meanwhile, so the block fills and stalls its input.
  initial begin : result_sink
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall = pick_gap();
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    steady = 1'b0;
    items_sent = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_WRITE;
    cmd_ch.pixel_index = '0;
    cmd_ch.range_count = '0;
    cmd_ch.in_red = '0;
    cmd_ch.in_green = '0;
    cmd_ch.in_blue = '0;
    cmd_ch.in_white = '0;
    cmd_ch.step_size = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DRAW_MODE;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: replace mode, full strip. The block
    // clears its store after reset, so the first reads must come back dark; the
    // handshake simply waits for the clearing pass to end.
    send_command(CMD_READ,  8'd0,   9'd0,   32'h0, 8'd0);
    send_command(CMD_WRITE, 8'd255, 9'd0,   32'hFFFF_FFFF, 8'd0);
    send_command(CMD_READ,  8'd255, 9'd0,   32'h0, 8'd0);
    send_command(CMD_WRITE, 8'd0,   9'd0,   32'hFE7F_8001, 8'd0);
    // An empty range touches nothing; a long one is cut at the end of the strip.
    send_command(CMD_FILL,  8'd0,   9'd0,   32'hAAAA_AAAA, 8'd0);
    send_command(CMD_FILL,  8'd250, 9'd511, 32'h4433_2211, 8'd0);
    send_command(CMD_READ,  8'd255, 9'd0,   32'h0, 8'd0);
    // Steps: a zero step changes nothing, a full step snaps to the target, and a
    // small one moves each channel in its own direction.
    send_command(CMD_STEP,  8'd0,   9'd256, 32'h0, 8'd0);
    send_command(CMD_STEP,  8'd248, 9'd8,   32'h4080_00FF, 8'hFF);
    send_command(CMD_STEP,  8'd0,   9'd1,   32'h00FF_00FF, 8'd7);
    send_command(CMD_READ,  8'd0,   9'd0,   32'h0, 8'd0);
    send_command(CMD_READ,  8'd250, 9'd0,   32'h0, 8'd0);

    // Saturating add, clipping on red and white.
    settle();
    write_reg(REG_DRAW_MODE, {7'd0, DRAW_ADD});
    send_command(CMD_WRITE, 8'd0,   9'd0,   32'h8000_01FF, 8'd0);
    send_command(CMD_READ,  8'd0,   9'd0,   32'h0, 8'd0);

    // Saturating subtract, flooring at zero.
    settle();
    write_reg(REG_DRAW_MODE, {7'd0, DRAW_SUB});
    send_command(CMD_WRITE, 8'd0,   9'd0,   32'hFF01_00FF, 8'd0);
    send_command(CMD_READ,  8'd0,   9'd0,   32'h0, 8'd0);

    // The unused mode code behaves as replace; a short strip flags writes and reads
    // past its end and cuts ranges short.
    settle();
    write_reg(REG_DRAW_MODE, 9'd3);
    write_reg(REG_ACTIVE_LEDS, 9'd10);
    send_command(CMD_WRITE, 8'd5,   9'd0,   32'h0102_0304, 8'd0);
    send_command(CMD_WRITE, 8'd10,  9'd0,   32'hFFFF_FFFF, 8'd0);
    send_command(CMD_READ,  8'd255, 9'd0,   32'h0, 8'd0);
    send_command(CMD_FILL,  8'd5,   9'd200, 32'h7766_5544, 8'd0);
    send_command(CMD_STEP,  8'd10,  9'd5,   32'h0, 8'hFF);
    send_command(CMD_READ,  8'd9,   9'd0,   32'h0, 8'd0);

    // An empty strip: everything is flagged or does nothing.
    settle();
    write_reg(REG_ACTIVE_LEDS, 9'd0);
    send_command(CMD_WRITE, 8'd0,   9'd0,   32'hFFFF_FFFF, 8'd0);
    send_command(CMD_READ,  8'd0,   9'd0,   32'h0, 8'd0);

    // Random phases over a spread of settings. Register words with upper bits set
    // check that only the low bits of the draw mode count, and an active length above
    // the store size is clamped. The phases with few live pixels are kept short.
    run_phase({7'd0, DRAW_REPLACE}, 9'd256, 280, 1'b0);
    run_phase({7'd0, DRAW_ADD},     9'd256, 280, 1'b0);
    run_phase({7'd0, DRAW_SUB},     9'd180, 250, 1'b1);
    run_phase(9'h1FF,               9'd300, 230, 1'b0);
    run_phase(9'h005,               9'd1,   80,  1'b0);
    run_phase({7'd0, DRAW_SUB},     9'd511, 280, 1'b1);
    run_phase({7'd0, DRAW_REPLACE}, 9'd0,   30,  1'b0);
    run_phase(9'($urandom_range(0, 3)), 9'($urandom_range(2, 256)), 300, 1'b0);

    // Drain: wait for the last results, then a margin for anything stray.
    settle();
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
